FILE: rtl/cbm_pkg.sv
// shared types, codes and constants of the cartridge bank mapper
// no dependencies; imported by every module of the block
package cbm_pkg;

	// default depth of the command queue between front and back
	localparam int unsigned QueueDepthDefault = 2;

	// bus operation codes
	localparam logic [2:0] OP_CPU_RD = 3'd0;
	localparam logic [2:0] OP_CPU_WR = 3'd1;
	localparam logic [2:0] OP_PPU_RD = 3'd2;
	localparam logic [2:0] OP_PPU_WR = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	// result target codes
	localparam logic [2:0] TGT_NONE   = 3'd0;
	localparam logic [2:0] TGT_PRG_RD = 3'd1;
	localparam logic [2:0] TGT_RAM_RD = 3'd2;
	localparam logic [2:0] TGT_RAM_WR = 3'd3;
	localparam logic [2:0] TGT_OPEN   = 3'd4;
	localparam logic [2:0] TGT_CHR_RD = 3'd5;
	localparam logic [2:0] TGT_CHR_WR = 3'd6;

	// configuration register indexes
	localparam logic [0:0] CFG_PRG_BANKS = 1'b0;
	localparam logic [0:0] CFG_CHR_BANKS = 1'b1;

	// register pages of cpu writes, counted from 0x8000
	localparam logic [2:0] PG_PRG01  = 3'd0;
	localparam logic [2:0] PG_PRG2   = 3'd1;
	localparam logic [2:0] PG_CHR01  = 3'd2;
	localparam logic [2:0] PG_CHR23  = 3'd3;
	localparam logic [2:0] PG_CHR45  = 3'd4;
	localparam logic [2:0] PG_CHR67  = 3'd5;
	localparam logic [2:0] PG_CTRL   = 3'd6;
	localparam logic [2:0] PG_IRQ    = 3'd7;

	localparam logic [1:0] PRG_FIXED_SLOT = 2'd3;
	localparam logic [8:0] PRESCALE_RELOAD = 9'd341;
	localparam logic [8:0] PRESCALE_DEC    = 9'd3;
	localparam logic [6:0] PRG_BANKS_MAX   = 7'd64;
	localparam logic [8:0] CHR_BANKS_MAX   = 9'd256;

	// remainder unit sizing
	localparam int unsigned REM_DVD_W   = 8;
	localparam int unsigned REM_PER_CYC = 2;
	localparam int unsigned REM_CYCLES  = REM_DVD_W / REM_PER_CYC;

	typedef enum logic [2:0] {
		K_NONE,
		K_RAM_RD,
		K_RAM_WR,
		K_PRG,
		K_REG,
		K_CHR_RD,
		K_CHR_WR,
		K_TICK
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  idx;   // prg slot, chr bank index or register page
		logic        sub;
		logic [12:0] low;   // offset inside the window
		logic [7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [0:0] index;
		logic [8:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic                 start;
		logic [REM_DVD_W-1:0] dividend;
		logic [REM_DVD_W:0]   divisor;
	} rem_req_t;

	typedef struct packed {
		logic                 done;
		logic [REM_DVD_W-1:0] rem;
	} rem_rsp_t;

endpackage

FILE: rtl/cbm_front.sv
// front end: takes bus words and classifies them into commands
// depends on cbm_pkg
module cbm_front (
	input  logic          s_valid,
	output logic          s_ready,
	input  logic [2:0]    op,
	input  logic [15:0]   address,
	input  logic [7:0]    write_data,
	output logic          push_valid,
	input  logic          push_ready,
	output cbm_pkg::cmd_t push_cmd
);
	import cbm_pkg::*;

	cmd_t cmd;

	always_comb begin
		cmd      = '0;
		cmd.kind = K_NONE;
		cmd.data = write_data;
		unique case (op)
			OP_CPU_RD: begin
				if (address[15]) begin
					cmd.kind = K_PRG;
					cmd.idx  = {1'b0, address[14:13]};
					cmd.low  = address[12:0];
				end else if (address[15:13] == 3'b011) begin
					cmd.kind = K_RAM_RD;
					cmd.low  = address[12:0];
				end
			end
			OP_CPU_WR: begin
				if (address[15]) begin
					cmd.kind = K_REG;
					cmd.idx  = address[14:12];
					cmd.sub  = |address[4:3];
				end else if (address[15:13] == 3'b011) begin
					cmd.kind = K_RAM_WR;
					cmd.low  = address[12:0];
				end
			end
			OP_PPU_RD, OP_PPU_WR: begin
				if (address[15:13] == 3'b000) begin
					cmd.kind = (op == OP_PPU_RD) ? K_CHR_RD : K_CHR_WR;
					cmd.idx  = address[12:10];
					cmd.low  = {3'b000, address[9:0]};
				end
			end
			OP_TICK: cmd.kind = K_TICK;
			default: cmd.kind = K_NONE;
		endcase
	end

	assign push_valid = s_valid;
	assign s_ready    = push_ready;
	assign push_cmd   = cmd;

endmodule

FILE: rtl/cbm_queue.sv
// short command queue between front and back ends
// depends on cbm_pkg
module cbm_queue #(
	parameter int unsigned Depth = cbm_pkg::QueueDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cbm_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output cbm_pkg::cmd_t pop_cmd
);
	import cbm_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != CntFull);
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

endmodule

FILE: rtl/cbm_rem.sv
// iterative remainder unit, restoring, REM_PER_CYC quotient bits per cycle while busy
// depends on cbm_pkg
module cbm_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  cbm_pkg::rem_req_t req,
	output cbm_pkg::rem_rsp_t rsp
);
	import cbm_pkg::*;

	localparam int unsigned CntW = (REM_CYCLES > 1) ? $clog2(REM_CYCLES) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(REM_CYCLES - 1);

	logic [REM_DVD_W-1:0] rem_q;
	logic [REM_DVD_W-1:0] dvd_q;
	logic [REM_DVD_W:0]   dsr_q;
	logic [CntW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REM_DVD_W-1:0] rem_nxt;
	logic [REM_DVD_W-1:0] dvd_nxt;
	logic [REM_DVD_W:0]   trial;

	// partial remainder stays below the divisor, so it fits the dividend width
	always_comb begin
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		trial   = '0;
		for (int i = 0; i < REM_PER_CYC; i++) begin
			trial = {rem_nxt, dvd_nxt[REM_DVD_W-1]};
			dvd_nxt = {dvd_nxt[REM_DVD_W-2:0], 1'b0};
			if (trial >= dsr_q) trial = trial - dsr_q;
			rem_nxt = trial[REM_DVD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntLast) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/cbm_back.sv
// back end: bank and irq state, command execution and the result register
// depends on cbm_pkg and cbm_rem
module cbm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cbm_pkg::cfg_wr_t cfg,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  cbm_pkg::cmd_t    cmd,
	output logic             m_valid,
	input  logic             m_ready,
	output logic [2:0]       target,
	output logic [18:0]      mapped_offset,
	output logic             irq_req,
	output logic [1:0]       mirroring
);
	import cbm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t     st_q;
	cmd_t       cmd_q;
	logic [6:0] cfg_prg_q;
	logic [8:0] cfg_chr_q;
	logic [5:0] prg_q [3];
	logic [7:0] chr_q [8];
	logic [7:0] ctrl_q;
	logic [7:0] latch_q;
	logic [7:0] count_q;
	logic [2:0] mode_q;
	logic [8:0] pre_q;
	logic       lvl_q;

	logic        out_valid_q;
	logic [2:0]  out_tgt_q;
	logic [18:0] out_off_q;
	logic        out_irq_q;
	logic [1:0]  out_mir_q;

	logic [6:0]  eff_prg;
	logic [8:0]  eff_chr;
	logic [5:0]  prg_sel;
	logic        need_div;
	logic        out_free;
	logic        fin_go;
	logic        tick_step;
	logic [8:0]  pre_nxt;
	logic [5:0]  bank_fixed;
	logic [2:0]  chr_wr_idx;
	logic [2:0]  fin_tgt;
	logic [18:0] fin_off;
	rem_req_t    rq;
	rem_rsp_t    rs;

	always_comb begin
		if (cfg_prg_q == '0) eff_prg = 7'd1;
		else if (cfg_prg_q > PRG_BANKS_MAX) eff_prg = PRG_BANKS_MAX;
		else eff_prg = cfg_prg_q;
		eff_chr = (cfg_chr_q > CHR_BANKS_MAX) ? CHR_BANKS_MAX : cfg_chr_q;
	end

	always_comb begin
		unique case (cmd.idx[1:0])
			2'd1:    prg_sel = prg_q[1];
			2'd2:    prg_sel = prg_q[2];
			default: prg_sel = prg_q[0];
		endcase
	end

	assign cmd_pop  = (st_q == ST_IDLE) && cmd_valid;
	assign need_div = ((cmd.kind == K_PRG) && (cmd.idx[1:0] != PRG_FIXED_SLOT)) ||
	                  (((cmd.kind == K_CHR_RD) || (cmd.kind == K_CHR_WR)) && (eff_chr != '0));

	always_comb begin
		rq.start    = cmd_pop && need_div;
		rq.dividend = (cmd.kind == K_PRG) ? {2'b00, prg_sel} : chr_q[cmd.idx];
		rq.divisor  = (cmd.kind == K_PRG) ? {2'b00, eff_prg} : eff_chr;
	end

	cbm_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rq),
		.rsp    (rs)
	);

	// irq timer step rules
	assign tick_step  = mode_q[1] && (mode_q[2] || (pre_q <= PRESCALE_DEC));
	assign pre_nxt    = (pre_q > PRESCALE_DEC) ? pre_q - PRESCALE_DEC
	                                           : pre_q + PRESCALE_RELOAD - PRESCALE_DEC;
	assign chr_wr_idx = {cmd.idx[1:0] - 2'd2, cmd.sub};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cfg_prg_q <= PRG_BANKS_MAX;
			cfg_chr_q <= CHR_BANKS_MAX;
			for (int i = 0; i < 3; i++) prg_q[i] <= '0;
			for (int i = 0; i < 8; i++) chr_q[i] <= '0;
			ctrl_q  <= '0;
			latch_q <= '0;
			count_q <= '0;
			mode_q  <= '0;
			pre_q   <= PRESCALE_RELOAD;
			lvl_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_PRG_BANKS: cfg_prg_q <= cfg.data[6:0];
					CFG_CHR_BANKS: cfg_chr_q <= cfg.data;
					default:       cfg_chr_q <= cfg_chr_q;
				endcase
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						st_q <= need_div ? ST_DIV : ST_FIN;
						if (cmd.kind == K_REG) begin
							unique case (cmd.idx)
								PG_PRG01: prg_q[{1'b0, cmd.sub}] <= cmd.data[5:0];
								PG_PRG2: begin
									if (!cmd.sub) prg_q[2] <= cmd.data[5:0];
								end
								PG_CHR01, PG_CHR23, PG_CHR45, PG_CHR67:
									chr_q[chr_wr_idx] <= cmd.data;
								PG_CTRL: begin
									if (cmd.sub) latch_q <= cmd.data;
									else ctrl_q <= cmd.data;
								end
								PG_IRQ: begin
									lvl_q <= 1'b0;
									if (cmd.sub) begin
										mode_q <= {mode_q[2], mode_q[0], mode_q[0]};
									end else begin
										mode_q <= cmd.data[2:0];
										if (cmd.data[1]) begin
											count_q <= latch_q;
											pre_q   <= PRESCALE_RELOAD;
										end
									end
								end
								default: lvl_q <= lvl_q;
							endcase
						end else if (cmd.kind == K_TICK) begin
							if (mode_q[1] && !mode_q[2]) pre_q <= pre_nxt;
							if (tick_step) begin
								if (count_q == 8'hFF) begin
									count_q <= latch_q;
									lvl_q   <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
						end
					end
				end
				ST_DIV: begin
					if (rs.done) st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd;
	end

	// result of the finished command
	assign bank_fixed = 6'(eff_prg - 7'd1);

	always_comb begin
		fin_tgt = TGT_NONE;
		fin_off = '0;
		unique case (cmd_q.kind)
			K_RAM_RD: begin
				if (ctrl_q[7]) begin
					fin_tgt = TGT_RAM_RD;
					fin_off = {6'd0, cmd_q.low};
				end else begin
					fin_tgt = TGT_OPEN;
				end
			end
			K_RAM_WR: begin
				if (ctrl_q[7]) begin
					fin_tgt = TGT_RAM_WR;
					fin_off = {6'd0, cmd_q.low};
				end
			end
			K_PRG: begin
				fin_tgt = TGT_PRG_RD;
				if (cmd_q.idx[1:0] == PRG_FIXED_SLOT) fin_off = {bank_fixed, cmd_q.low};
				else fin_off = {rs.rem[5:0], cmd_q.low};
			end
			K_CHR_RD, K_CHR_WR: begin
				if (eff_chr != '0) begin
					fin_tgt = (cmd_q.kind == K_CHR_RD) ? TGT_CHR_RD : TGT_CHR_WR;
					fin_off = {1'b0, rs.rem, cmd_q.low[9:0]};
				end
			end
			default: fin_tgt = TGT_NONE;
		endcase
	end

	assign out_free = !out_valid_q || m_ready;
	assign fin_go   = (st_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_tgt_q <= fin_tgt;
			out_off_q <= fin_off;
			out_irq_q <= lvl_q;
			out_mir_q <= ctrl_q[1:0];
		end
	end

	assign m_valid       = out_valid_q;
	assign target        = out_tgt_q;
	assign mapped_offset = out_off_q;
	assign irq_req       = out_irq_q;
	assign mirroring     = out_mir_q;

endmodule

FILE: rtl/cartridge_bank_mapper_irq.sv
// ticks, register writes and ram or open-bus accesses go from the back end's idle state to the
//   finish state; banked prg and chr accesses pass through the divide state, which waits
//   for the remainder unit to finish; the finish state loads the result register once it
//   is empty or m_ready is high, and then returns to idle
// the back end works on one command at a time; the queue keeps taking words while it has room
// reset (arst_n low, asynchronous): bank, control and irq registers cleared, prescaler 341,
//   bank counts 64 and 256, queue and result register empty
module cartridge_bank_mapper_irq #(
	parameter int unsigned QueueDepth = cbm_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// bus access or m2 tick in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic [2:0]  s_tuser,   // op[2:0]
	// mapped result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // mapped_offset[18:0], irq_req[19], mirroring[21:20], zero
	output logic [2:0]  m_tuser,   // target[2:0]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import cbm_pkg::*;

	logic        push_valid;
	logic        push_ready;
	cmd_t        push_cmd;
	logic        pop_valid;
	logic        pop;
	cmd_t        pop_cmd;
	cfg_wr_t     cfg;
	logic [2:0]  target;
	logic [18:0] mapped_offset;
	logic        irq_req;
	logic [1:0]  mirroring;

	// front end: decode op and address into a command word
	cbm_front u_front (
		.s_valid    (s_tvalid),
		.s_ready    (s_tready),
		.op         (s_tuser),
		.address    (s_tdata[15:0]),
		.write_data (s_tdata[23:16]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decouples classification from execution
	cbm_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	// config writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// back end: state updates, bank arithmetic, result register
	cbm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd_valid     (pop_valid),
		.cmd_pop       (pop),
		.cmd           (pop_cmd),
		.m_valid       (m_tvalid),
		.m_ready       (m_tready),
		.target        (target),
		.mapped_offset (mapped_offset),
		.irq_req       (irq_req),
		.mirroring     (mirroring)
	);

	// pack the result word
	assign m_tdata = {2'b00, mirroring, irq_req, mapped_offset};
	assign m_tuser = target;

endmodule
